// ===== sv/swfs_pkg.sv =====
// Package for the stop-and-wait frame stuffer: job and config types, phase enum,
// protocol constants and reset values. No dependencies.
`timescale 1ns / 1ps

package swfs_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [7:0] STUFF_XOR = 8'h20;
  localparam logic [7:0] CTRL_SEQ0 = 8'h00;
  localparam logic [7:0] CTRL_SEQ1 = 8'h40;
  localparam logic [7:0] ACK_SEQ0  = 8'h85;
  localparam logic [7:0] ACK_SEQ1  = 8'h05;

  localparam logic [7:0] FLAG_RST = 8'h7E;
  localparam logic [7:0] ESC_RST  = 8'h7D;
  localparam logic [7:0] ADDR_RST = 8'h03;

  // Configuration register indexes
  localparam logic [1:0] REG_FLAG = 2'd0;
  localparam logic [1:0] REG_ESC  = 2'd1;
  localparam logic [1:0] REG_ADDR = 2'd2;

  typedef struct packed {
    logic [7:0] flag;
    logic [7:0] esc;
    logic [7:0] addr;
  } swfs_cfg_t;

  // One classified input item, as queued between front and back
  typedef struct packed {
    logic       is_ack;
    logic       ack_ok;
    logic       first;
    logic       last;
    logic       seq;    // sequence bit seen when the item was accepted
    logic [7:0] data;
    logic [7:0] check;  // running check including this byte
  } swfs_job_t;

  typedef enum logic [2:0] {
    PH_OPEN,
    PH_ADDR,
    PH_CTRL,
    PH_HCS,
    PH_DATA,
    PH_CHECK,
    PH_CLOSE
  } swfs_phase_t;

endpackage

// ===== sv/stop_and_wait_frame_stuffer.sv =====
// Top level of the stop-and-wait frame stuffer: config registers, front end,
// job queue and back end. Depends on swfs_pkg, swfs_front, swfs_fifo, swfs_back.
// Throughput: one line byte per cycle from the single output register while the
// sink is ready and a job is queued; an item yields 1 to 12 beats, 1 or 2 for a
// mid-frame byte.
// Reset (rst_n low, synchronous): queue empty, sequence bit 1, check 0, registers
// back to flag 0x7E, escape 0x7D, address 0x03.
`timescale 1ns / 1ps

module stop_and_wait_frame_stuffer import swfs_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] data_byte, [15:8] response_control
  input  logic        in_tlast,   // last_byte
  input  logic [1:0]  in_tuser,   // [0] action, [1] first_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic        out_tlast,  // run_end
  output logic [1:0]  out_tuser,  // [0] result_kind, [1] ack_ok
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  swfs_cfg_t cfg_r, cfg_nxt;
  swfs_job_t push_job, pop_job;
  logic      q_push, q_full, q_pop, q_empty;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_FLAG: cfg_nxt.flag = cfg_data;
        REG_ESC:  cfg_nxt.esc  = cfg_data;
        REG_ADDR: cfg_nxt.addr = cfg_data;
        default:  cfg_nxt      = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.flag <= FLAG_RST;
      cfg_r.esc  <= ESC_RST;
      cfg_r.addr <= ADDR_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  swfs_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_tvalid),
    .in_ready         (in_tready),
    .action           (in_tuser[0]),
    .data_byte        (in_tdata[7:0]),
    .first_byte       (in_tuser[1]),
    .last_byte        (in_tlast),
    .response_control (in_tdata[15:8]),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_job            (push_job)
  );

  swfs_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  swfs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .job_valid  (!q_empty),
    .job        (pop_job),
    .job_pop    (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== sv/swfs_front.sv =====
// Front end: accepts input beats, checks acknowledges, keeps the sequence bit
// and running check, and pushes one job per item. Depends on swfs_pkg.
`timescale 1ns / 1ps

module swfs_front import swfs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       action,
  input  logic [7:0] data_byte,
  input  logic       first_byte,
  input  logic       last_byte,
  input  logic [7:0] response_control,
  input  logic       q_full,
  output logic       q_push,
  output swfs_job_t  q_job
);

  logic       seq_r, seq_nxt;
  logic [7:0] check_r, check_nxt;
  logic [7:0] expect_ctl;
  logic [7:0] check_new;
  logic       match;

  assign in_ready   = !q_full;
  assign q_push     = in_valid && !q_full;
  assign expect_ctl = seq_r ? ACK_SEQ1 : ACK_SEQ0;
  assign match      = (response_control == expect_ctl);
  assign check_new  = first_byte ? data_byte : (check_r ^ data_byte);

  always_comb begin
    q_job.is_ack = action;
    q_job.ack_ok = action && match;
    q_job.first  = first_byte;
    q_job.last   = last_byte;
    q_job.seq    = seq_r;
    q_job.data   = data_byte;
    q_job.check  = check_new;
  end

  always_comb begin
    seq_nxt   = seq_r;
    check_nxt = check_r;
    if (q_push) begin
      if (action) begin
        if (match) seq_nxt = !seq_r;
      end else begin
        check_nxt = last_byte ? 8'h00 : check_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r   <= 1'b1;
      check_r <= 8'h00;
    end else begin
      seq_r   <= seq_nxt;
      check_r <= check_nxt;
    end
  end

endmodule

// ===== sv/swfs_fifo.sv =====
// Small flop-based job queue between front and back.
// Depends on swfs_pkg for the job type.
`timescale 1ns / 1ps

module swfs_fifo import swfs_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  swfs_job_t push_job,
  output logic      full,
  input  logic      pop,
  output swfs_job_t pop_job,
  output logic      empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  swfs_job_t     mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == CNT_FULL);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_job;
  end

endmodule

// ===== sv/swfs_back.sv =====
// Back end: walks each queued job through header, payload and trailer, stuffs
// bytes and drives the registered output channel. Depends on swfs_pkg.
`timescale 1ns / 1ps

module swfs_back import swfs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  swfs_cfg_t  cfg,
  input  logic       job_valid,
  input  swfs_job_t  job,
  output logic       job_pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic       out_tlast,
  output logic [1:0] out_tuser
);

  swfs_phase_t phase_r, phase_nxt, cur_phase, adv_phase;
  logic        busy_r, busy_nxt;
  logic        esc_r, esc_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_data_r;
  logic        out_last_r;
  logic [1:0]  out_user_r;
  logic [7:0]  ctrl, raw;
  logic        stuffable, need_esc, esc_first, adv_done, step;
  logic [7:0]  byte_nxt;
  logic        last_nxt;

  assign step      = job_valid && (!out_valid_r || out_tready);
  assign cur_phase = busy_r ? phase_r : (job.first ? PH_OPEN : PH_DATA);
  assign ctrl      = job.seq ? CTRL_SEQ1 : CTRL_SEQ0;
  assign need_esc  = stuffable && ((raw == cfg.flag) || (raw == cfg.esc) || (raw == 8'h00));
  // escape beat goes out first, the XORed byte on the next beat
  assign esc_first = need_esc && !esc_r;

  always_comb begin
    raw       = cfg.flag;
    stuffable = 1'b1;
    adv_phase = PH_OPEN;
    adv_done  = 1'b0;
    case (cur_phase)
      PH_OPEN:  begin raw = cfg.flag;            stuffable = 1'b0; adv_phase = PH_ADDR; end
      PH_ADDR:  begin raw = cfg.addr;            adv_phase = PH_CTRL; end
      PH_CTRL:  begin raw = ctrl;                adv_phase = PH_HCS;  end
      PH_HCS:   begin raw = cfg.addr ^ ctrl;     adv_phase = PH_DATA; end
      PH_DATA:  begin
        raw       = job.data;
        adv_phase = PH_CHECK;
        adv_done  = !job.last;
      end
      PH_CHECK: begin raw = job.check;           adv_phase = PH_CLOSE; end
      PH_CLOSE: begin raw = cfg.flag;            stuffable = 1'b0; adv_done = 1'b1; end
      default:  begin raw = cfg.flag;            stuffable = 1'b0; adv_done = 1'b1; end
    endcase
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    busy_nxt  = busy_r;
    esc_nxt   = esc_r;
    job_pop   = 1'b0;
    if (step) begin
      if (job.is_ack) begin
        job_pop  = 1'b1;
        busy_nxt = 1'b0;
        esc_nxt  = 1'b0;
      end else if (esc_first) begin
        esc_nxt   = 1'b1;
        busy_nxt  = 1'b1;
        phase_nxt = cur_phase;
      end else begin
        esc_nxt = 1'b0;
        if (adv_done) begin
          job_pop  = 1'b1;
          busy_nxt = 1'b0;
        end else begin
          busy_nxt  = 1'b1;
          phase_nxt = adv_phase;
        end
      end
    end
  end

  // output beat
  always_comb begin
    if (job.is_ack) begin
      byte_nxt = 8'h00;
      last_nxt = 1'b1;
    end else if (esc_first) begin
      byte_nxt = cfg.esc;
      last_nxt = 1'b0;
    end else begin
      byte_nxt = esc_r ? (raw ^ STUFF_XOR) : raw;
      last_nxt = adv_done;
    end
    out_valid_nxt = step ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_OPEN;
      busy_r      <= 1'b0;
      esc_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      busy_r      <= busy_nxt;
      esc_r       <= esc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= byte_nxt;
      out_last_r <= last_nxt;
      out_user_r <= {job.is_ack && job.ack_ok, job.is_ack};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

`ifndef SYNTHESIS
  a_esc_in_job: assert property (@(posedge clk) disable iff (!rst_n)
    esc_r |-> busy_r)
    else $error("escape pending outside a job");

  a_pop_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |=> (out_tvalid && out_tlast))
    else $error("job retired without a closing beat");

  a_verdict_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tlast && (out_tdata == 8'h00)))
    else $error("malformed acknowledge verdict");
`endif

endmodule

// ===== tb/stop_and_wait_frame_stuffer_test.sv =====
// Testbench for stop_and_wait_frame_stuffer: directed and random frames, acks and
// register settings, checked beat by beat against a built-in frame predictor.
// Depends on swfs_pkg and the stop_and_wait_frame_stuffer RTL.
`timescale 1ns / 1ps

module stop_and_wait_frame_stuffer_test;
  import swfs_pkg::*;

  localparam logic [1:0] REG_SPARE = 2'd3;  // unmapped index, writes are dropped

  typedef enum logic {ACT_PAYLOAD = 1'b0, ACT_ACK = 1'b1} action_t;
  typedef enum logic {KIND_LINE = 1'b0, KIND_VERDICT = 1'b1} kind_t;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       run_end;
    kind_t      kind;
    logic       ok;
  } line_beat_t;

  // Predicts the stuffed line bytes and ack verdicts, queues them and checks
  // the beats leaving the block in order.
  class frame_scoreboard;
    logic [7:0] flag_val;
    logic [7:0] esc_val;
    logic [7:0] addr_val;
    logic       seq_bit;
    logic [7:0] check_acc;
    line_beat_t expected_beats[$];
    line_beat_t step_beats[$];
    int         errors;

    function new();
      flag_val  = FLAG_RST;
      esc_val   = ESC_RST;
      addr_val  = ADDR_RST;
      seq_bit   = 1'b1;
      check_acc = 8'h00;
      errors    = 0;
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        REG_FLAG: flag_val = val;
        REG_ESC:  esc_val  = val;
        REG_ADDR: addr_val = val;
        default: ;
      endcase
    endfunction

    function void emit(logic [7:0] b, kind_t k, logic ok);
      line_beat_t beat;
      beat.line_byte = b;
      beat.run_end   = 1'b0;
      beat.kind      = k;
      beat.ok        = ok;
      step_beats.push_back(beat);
    endfunction

    function void emit_stuffed(logic [7:0] b);
      if (b == flag_val || b == esc_val || b == 8'h00) begin
        emit(esc_val, KIND_LINE, 1'b0);
        emit(b ^ STUFF_XOR, KIND_LINE, 1'b0);
      end else begin
        emit(b, KIND_LINE, 1'b0);
      end
    endfunction

    function void note_input(action_t act, logic [7:0] data, logic first, logic last,
                             logic [7:0] resp);
      logic [7:0] ctrl;
      logic [7:0] ack_want;
      logic       hit;
      step_beats.delete();
      if (act == ACT_ACK) begin
        ack_want = seq_bit ? ACK_SEQ1 : ACK_SEQ0;
        hit = (resp == ack_want);
        if (hit) seq_bit = ~seq_bit;
        emit(8'h00, KIND_VERDICT, hit);
      end else begin
        if (first) begin
          ctrl = seq_bit ? CTRL_SEQ1 : CTRL_SEQ0;
          emit(flag_val, KIND_LINE, 1'b0);
          emit_stuffed(addr_val);
          emit_stuffed(ctrl);
          emit_stuffed(addr_val ^ ctrl);
          check_acc = data;
        end else begin
          check_acc = check_acc ^ data;
        end
        emit_stuffed(data);
        if (last) begin
          emit_stuffed(check_acc);
          emit(flag_val, KIND_LINE, 1'b0);
          check_acc = 8'h00;
        end
      end
      step_beats[step_beats.size() - 1].run_end = 1'b1;
      foreach (step_beats[i]) expected_beats.push_back(step_beats[i]);
    endfunction

    function void check_result(line_beat_t got);
      line_beat_t want;
      if (expected_beats.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected beat byte %02h end %0b kind %0b ok %0b", $time,
                   got.line_byte, got.run_end, got.kind, got.ok);
        return;
      end
      want = expected_beats.pop_front();
      if (got != want) begin
        errors++;
        if (errors <= 10)
          $display({"%0t: mismatch exp byte %02h end %0b kind %0b ok %0b,",
                    " got byte %02h end %0b kind %0b ok %0b"},
                   $time, want.line_byte, want.run_end, want.kind, want.ok,
                   got.line_byte, got.run_end, got.kind, got.ok);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // [7:0] data_byte, [15:8] response_control
  logic        in_tlast = 1'b0; // last_byte
  logic [1:0]  in_tuser = '0;   // [0] action, [1] first_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // [7:0] out_byte
  logic        out_tlast;       // run_end
  logic [1:0]  out_tuser;       // [0] result_kind, [1] ack_ok
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          phase_no = 0;
  logic        hold_on = 1'b0;
  logic [7:0]  cur_flag = FLAG_RST;
  logic [7:0]  cur_esc = ESC_RST;
  line_beat_t  seen_beat;

  frame_scoreboard sb = new();

  stop_and_wait_frame_stuffer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sink side: random stalls, forced low during the long hold-off
  always @(posedge clk) begin
    if (hold_on) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Beat monitor: values read here are the ones from before the edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        seen_beat.line_byte = out_tdata;
        seen_beat.run_end   = out_tlast;
        seen_beat.kind      = kind_t'(out_tuser[0]);
        seen_beat.ok        = out_tuser[1];
        sb.check_result(seen_beat);
      end
      if (in_tvalid && in_tready)
        sb.note_input(action_t'(in_tuser[0]), in_tdata[7:0], in_tuser[1], in_tlast,
                      in_tdata[15:8]);
      if (cfg_valid && cfg_ready)
        sb.write_reg(cfg_index, cfg_data);
    end
  end

  // Long sink hold-off while the source keeps pushing, to back up the queue
  initial begin
    wait (phase_no == 2);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (150) @(posedge clk);
    hold_on <= 1'b0;
  end

  initial begin
    #3_000_000;
    $display("status: fail");
    $finish;
  end

  task automatic send_item(action_t act, logic [7:0] data, logic first, logic last,
                           logic [7:0] resp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {resp, data};
    in_tlast  <= last;
    in_tuser  <= {first, act};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic apply_config(logic [7:0] flag, logic [7:0] esc, logic [7:0] addr,
                              bit with_spare);
    write_reg(REG_FLAG, flag);
    write_reg(REG_ESC, esc);
    write_reg(REG_ADDR, addr);
    if (with_spare) write_reg(REG_SPARE, 8'($urandom));
    cfg_valid <= 1'b0;
    cur_flag = flag;
    cur_esc  = esc;
  endtask

  // Drop valid, let every predicted beat drain, then a few quiet cycles.
  // The drain loop starts only after the monitor has logged the final input beat.
  task automatic wait_drained();
    int guard;
    guard = 0;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0 && guard < 50000) begin
      @(posedge clk);
      guard++;
    end
    repeat (6) @(posedge clk);
  endtask

  // Payload bytes lean toward the values that need stuffing
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(99);
    if (r < 12) return cur_flag;
    if (r < 24) return cur_esc;
    if (r < 34) return 8'h00;
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] pick_resp();
    case ($urandom_range(2))
      0: return ACK_SEQ0;
      1: return ACK_SEQ1;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic run_random(int n_items);
    int sent;
    int len;
    int r;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(99);
      if (r < 65) begin
        len = $urandom_range(6, 1);
        for (int i = 0; i < len; i++)
          send_item(ACT_PAYLOAD, pick_byte(), i == 0, i == len - 1, 8'($urandom));
        sent += len;
      end else if (r < 88) begin
        send_item(ACT_ACK, 8'($urandom), 1'($urandom), 1'($urandom), pick_resp());
        sent++;
      end else begin
        // stray marks: frames opened twice, continued or closed without a start
        send_item(ACT_PAYLOAD, pick_byte(), 1'($urandom), 1'($urandom), 8'($urandom));
        sent++;
      end
    end
  endtask

  task automatic run_phase(int n_items, logic [7:0] flag, logic [7:0] esc, logic [7:0] addr,
                           int idle_pct, int stall_pct, bit with_spare);
    wait_drained();
    apply_config(flag, esc, addr, with_spare);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    phase_no++;
    run_random(n_items);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: flag 7E, escape 7D, address 03, sequence bit 1
    send_item(ACT_PAYLOAD, 8'h7E, 1'b1, 1'b1, 8'h00);  // one-byte frame, flag in payload
    send_item(ACT_PAYLOAD, 8'h00, 1'b1, 1'b0, 8'hFF);
    send_item(ACT_PAYLOAD, 8'h7D, 1'b0, 1'b0, 8'h00);
    send_item(ACT_PAYLOAD, 8'hFF, 1'b0, 1'b0, 8'hAA);
    send_item(ACT_PAYLOAD, 8'h20, 1'b0, 1'b1, 8'h55);
    send_item(ACT_PAYLOAD, 8'h5A, 1'b0, 1'b0, 8'h00);  // continuation without a start
    send_item(ACT_PAYLOAD, 8'hA5, 1'b0, 1'b1, 8'h00);
    send_item(ACT_ACK, 8'h00, 1'b0, 1'b0, ACK_SEQ0);   // wrong ack for sequence 1
    send_item(ACT_ACK, 8'hFF, 1'b1, 1'b1, ACK_SEQ1);   // match, marks ignored
    send_item(ACT_PAYLOAD, 8'h01, 1'b1, 1'b1, 8'h00);  // zero control gets stuffed
    send_item(ACT_ACK, 8'h00, 1'b0, 1'b0, ACK_SEQ1);
    send_item(ACT_ACK, 8'h00, 1'b0, 1'b0, ACK_SEQ0);
    send_item(ACT_PAYLOAD, 8'hFF, 1'b1, 1'b0, 8'hFF);
    send_item(ACT_PAYLOAD, 8'hFF, 1'b0, 1'b1, 8'hFF);  // check byte comes out zero
    send_item(ACT_PAYLOAD, 8'h7D, 1'b1, 1'b1, 8'h00);
    send_item(ACT_ACK, 8'h00, 1'b0, 1'b0, 8'hFF);
    send_item(ACT_ACK, 8'hFF, 1'b0, 1'b0, 8'h00);
    run_random(20);

    run_phase(48, 8'h7E, 8'h7D, 8'h40, 78, 0, 1'b0);   // header XOR hits zero
    run_phase(48, 8'h00, 8'hFF, 8'hFF, 0, 78, 1'b0);   // extremes, hold-off here
    run_phase(48, 8'h55, 8'h55, 8'h00, 30, 30, 1'b0);  // flag equal to escape
    run_phase(48, 8'hFF, 8'h00, 8'h85, 0, 0, 1'b0);
    run_phase(48, 8'($urandom), 8'($urandom), 8'($urandom), 78, 0, 1'b0);
    run_phase(48, 8'($urandom), 8'($urandom), 8'($urandom), 0, 78, 1'b0);
    run_phase(48, 8'($urandom), 8'($urandom), 8'($urandom), 30, 30, 1'b1);

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
